@@ src/cnm_pkg.sv @@
`default_nettype none
package cnm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_AW   = 3;

  // register index, taken from the word address
  localparam logic REG_PHASE_STEP = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] q;
    logic signed [SAMPLE_W-1:0] i;
  } sample_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_out;
  } mix_ctl_t;

  // sine of a first-quadrant turn fraction u in [0, 2^30], result in Q30
  function automatic longint sin_q30(input longint unsigned u);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (u * 64'd1686629713) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    return sum;
  endfunction

  // clamp a two-bit-grown sum to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sum(input logic signed [SAMPLE_W+1:0] v);
    logic signed [SAMPLE_W-1:0] res;
    if (v > $signed({2'b00, 1'b0, {(SAMPLE_W-1){1'b1}}})) begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (v < $signed({2'b11, 1'b1, {(SAMPLE_W-1){1'b0}}})) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/complex_nco_mixer.sv @@
`default_nettype none
// channel   direction  payload
// in_       slave      tdata {q, i} 2 x 32 bit signed, tuser buffer_start
// out_      master     tdata {q, i} 2 x 32 bit signed, saturated
// cfg_      apb        phase_step at byte address 0
//
// one item per clock sustained while out_tready stays high; the result reaches out_tvalid
// through four registers: phase, sine ram read, products, sum and saturate
// after reset the sine ram is loaded, one entry a cycle, until all TABLE_SIZE entries are written,
// with in_tready low; configuration writes are taken meanwhile
// stalls hold each stage only while the stage after it is full, so bubbles close up
module complex_nco_mixer #(
  parameter int TABLE_SIZE = 1024,
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [63:0]                   in_tdata,  // in_i [31:0], in_q [63:32]
  input  wire logic                          in_tuser,  // buffer_start [0]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [63:0]                   out_tdata, // out_i [31:0], out_q [63:32]
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [cnm_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic      [31:0]                   cfg_prdata,
  output logic                               cfg_pready
);

  localparam int AW = $clog2(TABLE_SIZE);

  typedef logic signed [COEF_WIDTH-1:0] sine_tab_t [TABLE_SIZE];

  function automatic sine_tab_t build_tab();
    sine_tab_t       tab;
    longint unsigned t;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned u;
    longint          s;
    longint          e;
    longint          amp;
    amp = (64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      t    = (64'(k) << 32) / TABLE_SIZE;
      quad = (t >> 30) & 64'd3;
      r    = t & 64'h3FFF_FFFF;
      u    = quad[0] ? (64'h4000_0000 - r) : r;
      s    = cnm_pkg::sin_q30(u);
      if (s < 0) begin
        s = 0;
      end
      e      = (s * amp + 64'sd536870912) >>> 30;
      tab[k] = COEF_WIDTH'(quad[1] ? -e : e);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_tab();

  logic [31:0]             phase_step_r;
  logic                    cfg_wr;
  logic [AW:0]             fill_cnt_r;
  logic                    fill_done;
  logic                    v1_r;
  logic                    v2_r;
  logic                    v3_r;
  logic                    v4_r;
  logic                    rdy1;
  logic                    rdy2;
  logic                    rdy3;
  logic                    rdy4;
  logic                    accept;
  cnm_pkg::sample_t        s1_r;
  cnm_pkg::sample_t        s2_r;
  cnm_pkg::sample_t        res;
  cnm_pkg::mix_ctl_t       mix_ctl;
  logic [AW-1:0]           sin_idx;
  logic [AW-1:0]           cos_idx;
  logic [COEF_WIDTH-1:0]   sin_raw;
  logic [COEF_WIDTH-1:0]   cos_raw;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == cnm_pkg::REG_PHASE_STEP);
  assign cfg_prdata = (cfg_paddr[2] == cnm_pkg::REG_PHASE_STEP) ? phase_step_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= 32'd0;
    end else if (cfg_wr) begin
      phase_step_r <= cfg_pwdata;
    end
  end

  // sine ram load after reset
  assign fill_done = (fill_cnt_r == (AW+1)'(TABLE_SIZE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
    end else if (!fill_done) begin
      fill_cnt_r <= fill_cnt_r + 1'b1;
    end
  end

  // stage flow: a stage loads when empty or when the next one loads
  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = fill_done && rdy1;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= accept;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_tdata;
    end
    if (rdy2) begin
      s2_r <= s1_r;
    end
  end

  cnm_nco #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_nco (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .buffer_start (in_tuser),
    .phase_step   (phase_step_r),
    .sin_idx      (sin_idx),
    .cos_idx      (cos_idx)
  );

  cnm_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (TABLE_SIZE)
  ) u_sine_ram (
    .clk     (clk),
    .we      (!fill_done),
    .waddr   (fill_cnt_r[AW-1:0]),
    .wdata   (SINE_TAB[fill_cnt_r[AW-1:0]]),
    .re      (rdy2),
    .raddr_a (sin_idx),
    .raddr_b (cos_idx),
    .rdata_a (sin_raw),
    .rdata_b (cos_raw)
  );

  assign mix_ctl.ld_prod = rdy3;
  assign mix_ctl.ld_out  = rdy4;

  cnm_mix #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_mix (
    .clk      (clk),
    .ctl      (mix_ctl),
    .sin_coef ($signed(sin_raw)),
    .cos_coef ($signed(cos_raw)),
    .smp      (s2_r),
    .res      (res)
  );

  assign out_tvalid = v4_r;
  assign out_tdata  = res;

endmodule
`default_nettype wire

@@ src/cnm_ram.sv @@
`default_nettype none
module cnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule
`default_nettype wire

@@ src/cnm_nco.sv @@
`default_nettype none
module cnm_nco #(
  parameter int TABLE_SIZE = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic                          buffer_start,
  input  wire logic [31:0]                   phase_step,
  output logic      [$clog2(TABLE_SIZE)-1:0] sin_idx,
  output logic      [$clog2(TABLE_SIZE)-1:0] cos_idx
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int PW = 33 + AW;

  logic [31:0]   acc_r;
  logic [31:0]   acc_nxt;
  logic [31:0]   phase;
  logic [31:0]   phase_r;
  logic [31:0]   phase_cos;
  logic [PW-1:0] sin_prod;
  logic [PW-1:0] cos_prod;

  assign phase   = buffer_start ? 32'd0 : acc_r;
  assign acc_nxt = phase + phase_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
    end else if (accept) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      phase_r <= phase;
    end
  end

  // cosine is the sine a quarter turn on
  assign phase_cos = phase_r + 32'h4000_0000;

  // index = floor(phase * TABLE_SIZE / 2^32)
  assign sin_prod = PW'(phase_r) * PW'(TABLE_SIZE);
  assign cos_prod = PW'(phase_cos) * PW'(TABLE_SIZE);
  assign sin_idx  = sin_prod[32 +: AW];
  assign cos_idx  = cos_prod[32 +: AW];

endmodule
`default_nettype wire

@@ src/cnm_mix.sv @@
`default_nettype none
module cnm_mix #(
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire cnm_pkg::mix_ctl_t            ctl,
  input  wire logic signed [COEF_WIDTH-1:0] sin_coef,
  input  wire logic signed [COEF_WIDTH-1:0] cos_coef,
  input  wire cnm_pkg::sample_t             smp,
  output cnm_pkg::sample_t                  res
);

  localparam int SW = cnm_pkg::SAMPLE_W;
  localparam int PW = SW + COEF_WIDTH;

  logic signed [PW-1:0]   p_ci;
  logic signed [PW-1:0]   p_sq;
  logic signed [PW-1:0]   p_cq;
  logic signed [PW-1:0]   p_si;
  logic signed [PW-1:0]   p_ci_r;
  logic signed [PW-1:0]   p_sq_r;
  logic signed [PW-1:0]   p_cq_r;
  logic signed [PW-1:0]   p_si_r;
  logic signed [PW-1:0]   sh_ci;
  logic signed [PW-1:0]   sh_sq;
  logic signed [PW-1:0]   sh_cq;
  logic signed [PW-1:0]   sh_si;
  logic signed [SW+1:0]   sum_i;
  logic signed [SW+1:0]   sum_q;
  cnm_pkg::sample_t       res_r;

  assign p_ci = cos_coef * smp.i;
  assign p_sq = sin_coef * smp.q;
  assign p_cq = cos_coef * smp.q;
  assign p_si = sin_coef * smp.i;

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      p_ci_r <= p_ci;
      p_sq_r <= p_sq;
      p_cq_r <= p_cq;
      p_si_r <= p_si;
    end
  end

  // arithmetic shift truncates toward minus infinity
  assign sh_ci = p_ci_r >>> (COEF_WIDTH - 1);
  assign sh_sq = p_sq_r >>> (COEF_WIDTH - 1);
  assign sh_cq = p_cq_r >>> (COEF_WIDTH - 1);
  assign sh_si = p_si_r >>> (COEF_WIDTH - 1);

  assign sum_i = $signed(sh_ci[SW+1:0]) - $signed(sh_sq[SW+1:0]);
  assign sum_q = $signed(sh_cq[SW+1:0]) + $signed(sh_si[SW+1:0]);

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      res_r.i <= cnm_pkg::sat_sum(sum_i);
      res_r.q <= cnm_pkg::sat_sum(sum_q);
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

@@ test/complex_nco_mixer_checker.sv @@
`timescale 1ns / 1ps
module complex_nco_mixer_checker #(
  parameter int TABLE_SIZE = 1024,
  parameter int COEF_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [63:0]                in_tdata,  // in_i [31:0], in_q [63:32]
  input  logic                       in_tuser,  // buffer_start [0]
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [63:0]                out_tdata, // out_i [31:0], out_q [63:32]
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [cnm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  input  logic [31:0]                cfg_prdata,
  input  logic                       cfg_pready,
  output int                         outstanding,
  output int                         errors
);

  localparam int SHIFT = COEF_WIDTH - 1;
  localparam int CAW   = cnm_pkg::CFG_AW;

  typedef longint unsigned ulong_t;

  int                 sine_lut [TABLE_SIZE];
  logic [31:0]        step_reg;
  logic [31:0]        phase_acc;
  cnm_pkg::sample_t   mixed_q [$];

  // first-quadrant sine in q30, taylor series through the 15th power
  function automatic longint q30_sine(input longint unsigned u);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x    = (u * 64'd1686629713) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / ulong_t'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return acc;
  endfunction

  function automatic int lut_index(input logic [31:0] phase);
    return int'((ulong_t'(phase) * ulong_t'(TABLE_SIZE)) >> 32);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic cnm_pkg::sample_t rotate(input longint si, input longint sq,
                                              input logic [31:0] phase);
    longint           s;
    longint           c;
    cnm_pkg::sample_t res;
    s     = sine_lut[lut_index(phase)];
    c     = sine_lut[lut_index(phase + 32'h4000_0000)];
    res.i = clamp32(((c * si) >>> SHIFT) - ((s * sq) >>> SHIFT));
    res.q = clamp32(((c * sq) >>> SHIFT) + ((s * si) >>> SHIFT));
    return res;
  endfunction

  initial begin
    longint unsigned t;
    longint unsigned r;
    longint unsigned u;
    longint          s;
    longint          e;
    longint          amp;
    longint unsigned quad;
    errors      = 0;
    outstanding = 0;
    amp = (64'sd1 <<< SHIFT) - 1;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      t    = (ulong_t'(k) << 32) / ulong_t'(TABLE_SIZE);
      quad = (t >> 30) & 64'd3;
      r    = t & 64'h3FFF_FFFF;
      u    = quad[0] ? (64'h4000_0000 - r) : r;
      s    = q30_sine(u);
      if (s < 0) begin
        s = 0;
      end
      e = (s * amp + 64'sd536870912) >>> 30;
      sine_lut[k] = int'(quad[1] ? -e : e);
    end
  end

  always @(posedge clk) begin
    cnm_pkg::sample_t smp;
    cnm_pkg::sample_t got;
    cnm_pkg::sample_t want;
    logic [31:0]      phase;
    if (!rst_n) begin
      step_reg  = '0;
      phase_acc = '0;
      mixed_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready &&
          (cfg_paddr >> 2) == CAW'(cnm_pkg::REG_PHASE_STEP)) begin
        if (cfg_pwrite) begin
          step_reg = cfg_pwdata;
        end else if (cfg_prdata !== step_reg) begin
          $error("phase_step readback: expected %0h, actual %0h", step_reg, cfg_prdata);
          errors++;
        end
      end

      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (mixed_q.size() == 0) begin
          $error("unexpected result item: out_i %0d, out_q %0d", got.i, got.q);
          errors++;
        end else begin
          want = mixed_q.pop_front();
          if (got.i !== want.i) begin
            $error("out_i: expected %0d, actual %0d", want.i, got.i);
            errors++;
          end
          if (got.q !== want.q) begin
            $error("out_q: expected %0d, actual %0d", want.q, got.q);
            errors++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        smp   = in_tdata;
        // a buffer start rotates by phase zero and the phase carries on from there
        phase = in_tuser ? 32'h0 : phase_acc;
        mixed_q.push_back(rotate(longint'(smp.i), longint'(smp.q), phase));
        phase_acc = phase + step_reg;
      end
      outstanding <= mixed_q.size();
    end
  end

endmodule

@@ test/complex_nco_mixer_tb.sv @@
`timescale 1ns / 1ps
module complex_nco_mixer_tb;

  localparam int IDLE_LIMIT   = 10000;
  localparam int PHASE_ITEMS  = 240;
  localparam int UNUSED_REG   = 1;
  localparam int CAW          = cnm_pkg::CFG_AW;
  localparam logic [CAW-1:0] STEP_ADDR   = CAW'(cnm_pkg::REG_PHASE_STEP) << 2;
  localparam logic [CAW-1:0] UNUSED_ADDR = CAW'(UNUSED_REG << 2);

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic [63:0]       in_tdata    = '0;   // in_i [31:0], in_q [63:32]
  logic              in_tuser    = 1'b0; // buffer_start [0]
  logic              out_tready  = 1'b0;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CAW-1:0]    cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  wire               in_tready;
  wire               out_tvalid;
  wire  [63:0]       out_tdata;      // out_i [31:0], out_q [63:32]
  wire  [31:0]       cfg_prdata;
  wire               cfg_pready;
  int                outstanding;
  int                errors;
  int                quiet_cycles = 0;
  int                burst_left   = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  complex_nco_mixer DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  complex_nco_mixer_checker mixer_check (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .outstanding, .errors
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: ready runs of random length broken by short stalls
  initial begin
    int run;
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if ($urandom_range(0, 4) != 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  task automatic apb_xfer(input logic wr, input logic [CAW-1:0] addr,
                          input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // step writes only with the mixer empty; a write to the unused slot must not land
  task automatic set_step(input logic [31:0] step);
    drain();
    apb_xfer(1'b1, STEP_ADDR, step);
    apb_xfer(1'b0, STEP_ADDR, '0);
    apb_xfer(1'b1, UNUSED_ADDR, $urandom());
    apb_xfer(1'b0, STEP_ADDR, '0);
  endtask

  task automatic feed(input logic [31:0] si, input logic [31:0] sq, input logic start);
    cnm_pkg::sample_t smp;
    int               gap;
    smp.i = si;
    smp.q = sq;
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [31:0] pick_part();
    logic [7:0] b;
    b = 8'($urandom());
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return {{24{b[7]}}, b};
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] extreme_vals [4];
    logic [31:0] steps [8];
    int          n;
    extreme_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    steps = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), 32'h0040_0000,
              32'h0000_0001, 32'h8000_0000, $urandom(), 32'h4000_0000};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // eighth-turn step walks every octant, full-scale parts drive both rails
    set_step(32'h2000_0000);
    n = 0;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        feed(extreme_vals[a], extreme_vals[b], (n == 0 || n == 11));
        n++;
      end
    end
    feed(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    feed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    feed(32'h8000_0000, 32'h0000_0001, 1'b0);
    feed(32'h8000_0000, 32'h8000_0000, 1'b1);

    for (int p = 0; p < 8; p++) begin
      set_step(steps[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == PHASE_ITEMS / 2) begin
          drain();
        end
        feed(pick_part(), pick_part(), $urandom_range(0, 24) == 0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
